>>> design/psrm_pkg.sv
// ----------------------------------------------------------------------------
// psrm_pkg: shared types and constants
// Slot record, cell command, operation and status codes for the picture
// store reorder manager.
// ----------------------------------------------------------------------------
`default_nettype none

package psrm_pkg;

  localparam int          ENTRIES_DEF  = 16;
  localparam logic [7:0]  MAX_WAIT_RST = 8'd5;
  localparam logic [7:0]  WAIT_SAT     = 8'hFF;
  localparam logic [31:0] SEQ_RST      = 32'd1;
  localparam logic [63:0] TIME_INVALID = 64'h8000_0000_0000_0000;

  // operation codes of the func field
  typedef enum logic [2:0] {
    FN_ADD   = 3'd0,
    FN_TIMES = 3'd1,
    FN_DROP  = 3'd2,
    FN_SHOW  = 3'd3,
    FN_ALLOC = 3'd4,
    FN_FLUSH = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2,
    STAT_PEND = 2'd3
  } status_e;

  // command broadcast to the cells
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_ADD,
    CMD_TIMES,
    CMD_DROP,
    CMD_SHOW,
    CMD_FLUSH
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_e;

  typedef struct packed {
    logic        is_ref;
    logic        in_use;
    logic        shown;
    logic [31:0] order;
    logic [63:0] start;
    logic [63:0] stop;
  } slot_t;

  typedef struct packed {
    cmd_e        op;
    logic        is_ref;
    logic        set_times;
    logic [31:0] order;
    logic [63:0] start;
    logic [63:0] stop;
  } cmd_t;

  localparam slot_t SLOT_RST = '{
    is_ref: 1'b0, in_use: 1'b0, shown: 1'b0, order: 32'd0,
    start: TIME_INVALID, stop: TIME_INVALID
  };

endpackage

`default_nettype wire

>>> design/psrm_if.sv
// ----------------------------------------------------------------------------
// psrm_if: channel interfaces
// Request, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface psrm_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [3:0]         surface_index;
  logic               is_reference;
  logic               is_field;
  logic signed [63:0] start_time;
  logic signed [63:0] stop_time;

  modport source (output valid, func, surface_index, is_reference, is_field,
                  start_time, stop_time, input ready);
  modport sink   (input valid, func, surface_index, is_reference, is_field,
                  start_time, stop_time, output ready);
endinterface

interface psrm_rsp_if;
  logic               valid;
  logic               ready;
  logic [3:0]         slot_index;
  logic [1:0]         status;
  logic               deliver;
  logic signed [63:0] start_out;
  logic signed [63:0] stop_out;

  modport source (output valid, slot_index, status, deliver, start_out, stop_out,
                  input ready);
  modport sink   (input valid, slot_index, status, deliver, start_out, stop_out,
                  output ready);
endinterface

interface psrm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> design/psrm_cell.sv
// ----------------------------------------------------------------------------
// psrm_cell: one surface slot
// Holds a slot record, takes its neighbor's record while the ring rotates
// and applies broadcast commands when addressed; flush clears every cell.
// ----------------------------------------------------------------------------
`default_nettype none

module psrm_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire psrm_pkg::slot_t shift_data_i,
  input  wire psrm_pkg::cmd_t  cmd_i,
  input  wire logic            hit_i,
  output psrm_pkg::slot_t      slot_o
);
  import psrm_pkg::*;

  slot_t slot_q, slot_d;

  // next record: rotate, or apply command
  always_comb begin
    logic rel;
    rel    = 1'b0;
    slot_d = slot_q;
    if (shift_i) begin
      slot_d = shift_data_i;
    end else begin
      case (cmd_i.op)
        CMD_ADD: begin
          if (hit_i) begin
            slot_d.is_ref = cmd_i.is_ref;
            slot_d.in_use = 1'b1;
            slot_d.shown  = 1'b0;
            if (cmd_i.set_times) begin
              slot_d.start = cmd_i.start;
              slot_d.stop  = cmd_i.stop;
            end
          end
        end
        CMD_TIMES: begin
          if (hit_i) begin
            slot_d.start = cmd_i.start;
            slot_d.stop  = cmd_i.stop;
          end
        end
        CMD_DROP: begin
          if (hit_i) begin
            slot_d.is_ref = 1'b0;
            rel           = slot_q.shown;
          end
        end
        CMD_SHOW: begin
          if (hit_i) begin
            slot_d.shown = 1'b1;
            rel          = !slot_q.is_ref;
          end
        end
        CMD_FLUSH: slot_d = SLOT_RST;
        default: ;
      endcase
      // freeing stamps the slot with the running free sequence
      if (rel) begin
        slot_d.order  = cmd_i.order;
        slot_d.in_use = 1'b0;
        slot_d.shown  = 1'b0;
        slot_d.start  = TIME_INVALID;
        slot_d.stop   = TIME_INVALID;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= SLOT_RST;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire

>>> design/picture_store_reorder_manager.sv
// Picture store reorder manager. Slots live in a ring of ENTRIES cells. Add,
// update times, drop reference and flush go from request transfer through the
// apply step to the output register; display next (when enough pictures
// wait) and allocate first scan the ring, which rotates once past a single
// compare unit at its head, one slot per cycle. One request is in work at a
// time; a finished result waits in the output register while the next
// request is taken.
// ----------------------------------------------------------------------------
// picture_store_reorder_manager: top level
// Control sequencer, scan compare unit, globals and the cell ring.
// ----------------------------------------------------------------------------
`default_nettype none

module picture_store_reorder_manager #(
  parameter int ENTRIES = psrm_pkg::ENTRIES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  psrm_req_if.sink   in_ch_i,
  psrm_rsp_if.source out_ch_o,
  psrm_cfg_if.sink   cfg_ch_i
);
  import psrm_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  state_e state_q, state_d;

  // latched request
  logic [2:0]  func_q;
  logic [3:0]  sidx_q;
  logic        ref_q, field_q;
  logic [63:0] tstart_q, tstop_q;

  // scan results
  logic [IW-1:0] cnt_q;
  logic          found_q;
  logic [IW-1:0] best_idx_q;
  logic [63:0]   best_start_q, best_stop_q;
  logic [31:0]   best_order_q;
  logic          best_ref_q;

  // globals
  logic [7:0]  max_wait_q;
  logic [7:0]  wait_q, wait_d;
  logic [31:0] seq_q, seq_d;
  logic        pend_q, pend_d;

  // output register
  logic        out_valid_q;
  logic [3:0]  out_slot_q, out_slot_d;
  logic [1:0]  out_status_q, out_status_d;
  logic        out_deliver_q, out_deliver_d;
  logic [63:0] out_start_q, out_start_d, out_stop_q, out_stop_d;

  slot_t         slots [ENTRIES];
  cmd_t          cmd;
  logic [IW-1:0] tgt;
  logic          in_acc, fire, in_range, shift, take;
  slot_t         head;

  assign in_acc   = in_ch_i.valid && in_ch_i.ready;
  assign in_ch_i.ready = (state_q == S_IDLE);
  assign fire     = (state_q == S_APPLY) && (!out_valid_q || out_ch_o.ready);
  assign in_range = ({28'd0, sidx_q} < 32'(ENTRIES));
  assign shift    = (state_q == S_SCAN);
  assign head     = slots[0];
  assign tgt      = (func_q == FN_SHOW) ? best_idx_q : IW'(sidx_q);

  // configuration register
  assign cfg_ch_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_wait_q <= MAX_WAIT_RST;
    end else if (cfg_ch_i.valid) begin
      max_wait_q <= cfg_ch_i.data;
    end
  end

  // cell ring: cell k takes cell k+1, cell 0 is the compare head
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    slot_t nb;
    if (k == ENTRIES - 1) begin : g_wrap
      assign nb = slots[0];
    end else begin : g_next
      assign nb = slots[k+1];
    end
    psrm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (shift),
      .shift_data_i(nb),
      .cmd_i       (cmd),
      .hit_i       (tgt == IW'(k)),
      .slot_o      (slots[k])
    );
  end

  // head compare during the scan
  always_comb begin
    if (func_q == FN_SHOW) begin
      take = head.in_use && !head.shown &&
             (!found_q || ($signed(head.start) < $signed(best_start_q)));
    end else begin
      take = !head.in_use && (!found_q || (head.order < best_order_q));
    end
  end

  // sequencer, commands and result
  always_comb begin
    logic rel;
    rel           = 1'b0;
    state_d       = state_q;
    wait_d        = wait_q;
    seq_d         = seq_q;
    pend_d        = pend_q;
    cmd           = '{op: CMD_NONE, is_ref: ref_q, set_times: !field_q,
                      order: seq_q, start: tstart_q, stop: tstop_q};
    out_slot_d    = 4'd0;
    out_status_d  = STAT_OK;
    out_deliver_d = 1'b0;
    out_start_d   = 64'd0;
    out_stop_d    = 64'd0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if ((in_ch_i.func == FN_SHOW && wait_q > max_wait_q) ||
              in_ch_i.func == FN_ALLOC) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_APPLY;
          end
        end
      end
      S_SCAN: begin
        if (cnt_q == IW'(ENTRIES - 1)) state_d = S_APPLY;
      end
      S_APPLY: begin
        if (fire) begin
          state_d = S_IDLE;
          case (func_q)
            FN_ADD: begin
              if (in_range) begin
                if (field_q && !pend_q) begin
                  pend_d        = 1'b1;
                  cmd.op        = CMD_TIMES;
                  out_status_d  = STAT_PEND;
                end else begin
                  cmd.op = CMD_ADD;
                  pend_d = 1'b0;
                  if (wait_q != WAIT_SAT) wait_d = wait_q + 8'd1;
                end
              end
            end
            FN_TIMES: if (in_range) cmd.op = CMD_TIMES;
            FN_DROP: begin
              if (in_range) begin
                cmd.op = CMD_DROP;
                rel    = slots[tgt].shown;
              end
            end
            FN_SHOW: begin
              if (found_q) begin
                cmd.op        = CMD_SHOW;
                rel           = !best_ref_q;
                out_slot_d    = 4'(best_idx_q);
                out_start_d   = best_start_q;
                out_stop_d    = best_stop_q;
                out_deliver_d = !best_start_q[63];
              end else begin
                out_status_d = STAT_NONE;
              end
            end
            FN_ALLOC: begin
              if (found_q) begin
                out_slot_d = 4'(best_idx_q);
              end else begin
                cmd.op       = CMD_FLUSH;
                out_status_d = STAT_FULL;
              end
            end
            FN_FLUSH: cmd.op = CMD_FLUSH;
            default: ;
          endcase
          if (rel) begin
            seq_d = seq_q + 32'd1;
            if (wait_q != 8'd0) wait_d = wait_q - 8'd1;
          end
          if (cmd.op == CMD_FLUSH) begin
            seq_d  = SEQ_RST;
            wait_d = 8'd0;
            pend_d = 1'b0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= 8'd0;
      seq_q       <= SEQ_RST;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      seq_q   <= seq_d;
      pend_q  <= pend_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else if (shift) begin
        cnt_q <= cnt_q + IW'(1);
        if (take) found_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q   <= in_ch_i.func;
      sidx_q   <= in_ch_i.surface_index;
      ref_q    <= in_ch_i.is_reference;
      field_q  <= in_ch_i.is_field;
      tstart_q <= in_ch_i.start_time;
      tstop_q  <= in_ch_i.stop_time;
    end
    if (shift && take) begin
      best_idx_q   <= cnt_q;
      best_start_q <= head.start;
      best_stop_q  <= head.stop;
      best_order_q <= head.order;
      best_ref_q   <= head.is_ref;
    end
    if (fire) begin
      out_slot_q    <= out_slot_d;
      out_status_q  <= out_status_d;
      out_deliver_q <= out_deliver_d;
      out_start_q   <= out_start_d;
      out_stop_q    <= out_stop_d;
    end
  end

  assign out_ch_o.valid      = out_valid_q;
  assign out_ch_o.slot_index = out_slot_q;
  assign out_ch_o.status     = out_status_q;
  assign out_ch_o.deliver    = out_deliver_q;
  assign out_ch_o.start_out  = out_start_q;
  assign out_ch_o.stop_out   = out_stop_q;

`ifndef SYNTHESIS
  // a result is only loaded from the apply step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_APPLY)
    else $error("result loaded outside apply step");

  // globals only change in the apply step, so they cannot move during a scan
  a_scan_globals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> $stable(wait_q) && $stable(seq_q))
    else $error("globals changed during scan");

  // the scan leaves after exactly one full rotation
  a_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && cnt_q == IW'(ENTRIES - 1)) |=> state_q == S_APPLY)
    else $error("scan did not end after a full rotation");
`endif

endmodule

`default_nettype wire

>>> sim/psrm_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrm_tb_if: testbench-side channel records
// Channel interfaces come from the design; this file holds the packed operation
// and result records that the testbench uses for the request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

package psrm_tb_pkg;
  import psrm_pkg::*;

  // one picture operation as the request channel carries it
  typedef struct packed {
    logic [2:0]         func;
    logic [3:0]         surface_index;
    logic               is_reference;
    logic               is_field;
    logic signed [63:0] start_time;
    logic signed [63:0] stop_time;
  } pic_op_t;

  // one result as the result channel carries it
  typedef struct packed {
    logic [3:0]         slot_index;
    logic [1:0]         status;
    logic               deliver;
    logic signed [63:0] start_out;
    logic signed [63:0] stop_out;
  } pic_res_t;
endpackage

`default_nettype wire

>>> sim/picture_store_reorder_manager_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picture_store_reorder_manager_tb: self-checking testbench
// Drives directed and random picture operations through the request channel,
// predicts each result with a behavioral copy of the slot store or a typed row,
// compares each result field by field; some phases idle both sides at random.
// ----------------------------------------------------------------------------
`default_nettype none

module picture_store_reorder_manager_tb;
  import psrm_pkg::*;
  import psrm_tb_pkg::*;

  localparam int NSLOT = 16;
  localparam logic [4:0] NO_PEND = 5'd16;
  localparam logic [3:0] ANY = 4'd0;
  localparam logic [63:0] TMAX = 64'h7FFF_FFFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  psrm_req_if req_ch();
  psrm_rsp_if rsp_ch();
  psrm_cfg_if cfg_ch();

  picture_store_reorder_manager dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (req_ch.sink),
    .out_ch_o(rsp_ch.source),
    .cfg_ch_i(cfg_ch.sink)
  );

  // predictor state: copy of the slot store
  logic [7:0]  p_max_wait;
  logic        p_ref   [NSLOT];
  logic        p_used  [NSLOT];
  logic        p_shown [NSLOT];
  logic [31:0] p_order [NSLOT];
  logic [63:0] p_start [NSLOT];
  logic [63:0] p_stop  [NSLOT];
  logic [4:0]  p_pend;
  logic [7:0]  p_wait;
  logic [31:0] p_seq;

  pic_res_t results_due[$];
  int n_fail = 0;
  int send_idle = 0;   // percent of cycles the sender idles
  int recv_stall = 0;  // percent of cycles the receiver stalls

  function automatic void store_clear();
    for (int i = 0; i < NSLOT; i++) begin
      p_ref[i] = 1'b0; p_used[i] = 1'b0; p_shown[i] = 1'b0; p_order[i] = '0;
      p_start[i] = TIME_INVALID; p_stop[i] = TIME_INVALID;
    end
    p_pend = NO_PEND;
    p_wait = '0;
    p_seq = SEQ_RST;
  endfunction

  function automatic void slot_free(int s);
    p_order[s] = p_seq;
    p_seq++;
    p_used[s] = 1'b0; p_shown[s] = 1'b0;
    p_start[s] = TIME_INVALID; p_stop[s] = TIME_INVALID;
    if (p_wait != 0) p_wait--;
  endfunction

  // apply one operation to the store copy and return the result it yields
  function automatic pic_res_t store_apply(pic_op_t op);
    pic_res_t r;
    int s;
    int pick;
    r = '0;
    s = op.surface_index;
    pick = -1;
    case (op.func)
      FN_ADD: begin
        if (op.is_field && p_pend == NO_PEND) begin
          p_pend = 5'(s);
          p_start[s] = op.start_time; p_stop[s] = op.stop_time;
          r.status = STAT_PEND;
        end else begin
          p_ref[s] = op.is_reference; p_used[s] = 1'b1; p_shown[s] = 1'b0;
          if (!op.is_field) begin
            p_start[s] = op.start_time; p_stop[s] = op.stop_time;
          end
          p_pend = NO_PEND;
          if (p_wait != WAIT_SAT) p_wait++;
        end
      end
      FN_TIMES: begin
        p_start[s] = op.start_time; p_stop[s] = op.stop_time;
      end
      FN_DROP: begin
        p_ref[s] = 1'b0;
        if (p_shown[s]) slot_free(s);
      end
      FN_SHOW: begin
        if (p_wait > p_max_wait)
          for (int i = 0; i < NSLOT; i++)
            if (p_used[i] && !p_shown[i] &&
                (pick < 0 || $signed(p_start[i]) < $signed(p_start[pick]))) pick = i;
        if (pick < 0) r.status = STAT_NONE;
        else begin
          r.slot_index = 4'(pick);
          r.start_out = p_start[pick]; r.stop_out = p_stop[pick];
          r.deliver = ~p_start[pick][63];
          p_shown[pick] = 1'b1;
          if (!p_ref[pick]) slot_free(pick);
        end
      end
      FN_ALLOC: begin
        for (int i = 0; i < NSLOT; i++)
          if (!p_used[i] && (pick < 0 || p_order[i] < p_order[pick])) pick = i;
        if (pick < 0) begin
          store_clear();
          r.status = STAT_FULL;
        end else r.slot_index = 4'(pick);
      end
      FN_FLUSH: store_clear();
      default: ;
    endcase
    return r;
  endfunction

  // receiver: random stall, check each result transfer
  always @(negedge clk_i) begin
    if (rst_ni) rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    pic_res_t got, want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.slot_index, rsp_ch.status, rsp_ch.deliver,
              rsp_ch.start_out, rsp_ch.stop_out};
      if (results_due.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected result %h", got);
      end else begin
        want = results_due.pop_front();
        if (got !== want) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch: exp slot %0d st %0d dl %0d %h %h, got slot %0d st %0d dl %0d %h %h",
                     want.slot_index, want.status, want.deliver, want.start_out,
                     want.stop_out, got.slot_index, got.status, got.deliver,
                     got.start_out, got.stop_out);
        end
      end
    end
  end

  // send one operation; a typed row overrides the predicted result
  // valid stays up after the transfer until the next call or drain
  task automatic send_op(pic_op_t op, logic use_typed, pic_res_t typed);
    pic_res_t r;
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    {req_ch.func, req_ch.surface_index, req_ch.is_reference, req_ch.is_field,
     req_ch.start_time, req_ch.stop_time} <= op;
    do @(posedge clk_i); while (!req_ch.ready);
    r = store_apply(op);
    results_due.push_back(use_typed ? typed : r);
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_max_wait(logic [7:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    p_max_wait = v;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic pic_op_t mk(logic [2:0] f, logic [3:0] s, logic rf, logic fd,
                                 logic [63:0] a, logic [63:0] b);
    return '{f, s, rf, fd, a, b};
  endfunction

  function automatic logic [63:0] rand_time();
    case ($urandom_range(5))
      0: return TIME_INVALID;
      1: return TMAX;
      2: return 64'($urandom_range(1000));
      3: return -64'($urandom_range(1000));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly add/show traffic so display selection runs often
  function automatic pic_op_t rand_op();
    int k;
    logic [2:0] f;
    k = $urandom_range(99);
    if (k < 40) f = FN_ADD;
    else if (k < 65) f = FN_SHOW;
    else if (k < 77) f = FN_DROP;
    else if (k < 87) f = FN_ALLOC;
    else if (k < 94) f = FN_TIMES;
    else if (k < 96) f = FN_FLUSH;
    else f = 3'($urandom_range(7));
    return mk(f, 4'($urandom), 1'($urandom), ($urandom_range(4) == 0),
              rand_time(), rand_time());
  endfunction

  // directed stimulus rows; typed = result can be read off directly
  typedef struct {
    pic_op_t  op;
    logic     typed;
    pic_res_t res;
  } row_t;

  row_t rows[$];

  initial begin
    pic_res_t ok;
    int phase_idle[4] = '{0, 72, 0, 30};
    int phase_stall[4] = '{0, 0, 72, 30};
    logic [7:0] waits[4] = '{8'd0, 8'd255, 8'd1, 8'd3};
    ok = '0;
    req_ch.valid = 1'b0;
    {req_ch.func, req_ch.surface_index, req_ch.is_reference, req_ch.is_field,
     req_ch.start_time, req_ch.stop_time} = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    p_max_wait = MAX_WAIT_RST;
    store_clear();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, reset max_waiting first
    rows.push_back('{mk(FN_SHOW, ANY, 0, 0, 0, 0), 1, '{0, STAT_NONE, 0, 0, 0}});
    rows.push_back('{mk(FN_ALLOC, ANY, 0, 0, 0, 0), 1, '{0, STAT_OK, 0, 0, 0}});
    rows.push_back('{mk(FN_ADD, 4'd3, 1, 1, 64'd7, 64'd9), 1,
                     '{0, STAT_PEND, 0, 0, 0}});
    rows.push_back('{mk(FN_ADD, 4'd3, 1, 1, 0, 0), 1, ok});
    rows.push_back('{mk(FN_ADD, 4'd15, 0, 0, TMAX, TMAX), 0, ok});
    rows.push_back('{mk(FN_ADD, 4'd0, 0, 0, TIME_INVALID, 64'd1), 0, ok});
    rows.push_back('{mk(FN_ADD, 4'd1, 1, 0, -64'sd5, 64'd2), 0, ok});
    rows.push_back('{mk(FN_ADD, 4'd2, 0, 0, 64'd5, 64'd6), 0, ok});
    rows.push_back('{mk(FN_ADD, 4'd4, 0, 0, 64'd5, 64'd6), 0, ok});
    rows.push_back('{mk(FN_TIMES, 4'd4, 0, 0, 64'd4, -64'sd1), 1, ok});
    for (int i = 0; i < 4; i++) rows.push_back('{mk(FN_SHOW, ANY, 0, 0, 0, 0), 0, ok});
    rows.push_back('{mk(FN_DROP, 4'd1, 0, 0, 0, 0), 1, ok});
    rows.push_back('{mk(3'd6, 4'd9, 1, 1, TMAX, TMAX), 1, ok});
    rows.push_back('{mk(3'd7, 4'd9, 1, 1, TMAX, TMAX), 1, ok});
    for (int i = 0; i < NSLOT; i++)
      rows.push_back('{mk(FN_ADD, 4'(i), 1, 0, 64'(i), 64'(i)), 0, ok});
    rows.push_back('{mk(FN_ALLOC, ANY, 0, 0, 0, 0), 1, '{0, STAT_FULL, 0, 0, 0}});
    rows.push_back('{mk(FN_FLUSH, ANY, 0, 0, 0, 0), 1, ok});
    foreach (rows[i]) send_op(rows[i].op, rows[i].typed, rows[i].res);
    drain();

    // random part in four phases, each with its own idling, stalling and max_waiting
    for (int ph = 0; ph < 4; ph++) begin
      write_max_wait(waits[ph]);
      send_idle = phase_idle[ph];
      recv_stall = phase_stall[ph];
      for (int n = 0; n < 250; n++) begin
        send_op(rand_op(), 1'b0, ok);
        if (n == 125) drain();
      end
      drain();
    end
    write_max_wait(8'd0);
    for (int n = 0; n < 60; n++) send_op(rand_op(), 1'b0, ok);
    drain();

    if (n_fail == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
